// ===== hw/rtl/fba_pkg.sv =====
package fba_pkg;

   localparam int NUM_FRAMES_DEFAULT = 4096;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int MODE_W = 2;
   localparam int FRAME_W = 12;
   localparam int COUNT_W = 13;
   localparam int ZONE_W = 13;
   localparam int CSR_INDEX_W = 1;

   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_ZONE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_ZONE = 1'b1;

   localparam logic [ZONE_W-1:0] HIGH_ZONE_RESET = 13'd3584;
   localparam logic [ZONE_W-1:0] NORMAL_ZONE_RESET = 13'd256;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [FRAME_W-1:0] start_frame;
      logic [COUNT_W-1:0] frame_count;
      logic               want_high;
      logic               want_normal;
   } req_type;

   typedef struct packed {
      logic               success;
      logic [FRAME_W-1:0] result_frame;
   } rsp_type;

endpackage

// ===== hw/rtl/fba_word_scan.sv =====
module fba_word_scan #(
   parameter int WORD_BITS = 32,
   parameter int FW = 14
) (
   input  logic [WORD_BITS-1:0]         busy,
   input  logic [FW-1:0]                run_in,
   input  logic [FW-1:0]                need,
   output logic                         hit,
   output logic [$clog2(WORD_BITS)-1:0] hit_bit,
   output logic [FW-1:0]                run_out
);
   localparam int BW = $clog2(WORD_BITS);

   logic [FW-1:0] run_len [WORD_BITS];

   // Length of the free run that ends at each bit, counting the run carried in
   // from earlier words when no busy bit lies at or below it.
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         logic any_busy;
         int   last_busy;
         any_busy = 1'b0;
         last_busy = 0;
         for (int j = 0; j <= i; j++) begin
            if (busy[j]) begin
               any_busy = 1'b1;
               last_busy = j;
            end
         end
         if (any_busy) begin
            run_len[i] = FW'(i - last_busy);
         end else begin
            run_len[i] = run_in + FW'(i + 1);
         end
      end
   end

   always_comb begin
      hit = 1'b0;
      hit_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (run_len[i] >= need) begin
            hit = 1'b1;
            hit_bit = BW'(i);
         end
      end
   end

   assign run_out = run_len[WORD_BITS-1];

endmodule

// ===== hw/rtl/frame_bitmap_allocator.sv =====
// Channel   Direction  Payload         Handshake
// req       in         req_type        req_valid / req_ready
// rsp       out        rsp_type        rsp_valid / rsp_ready
// csr       in         index 1 bit,    csr_valid / csr_ready (always ready)
//                      data 13 bits
// After reset a clearing pass writes all ones into the map, one word per cycle,
// with req_ready low. Free and reserve read, then write back, each touched word.
// Allocate streams one map word per cycle through the word scanner from the
// zone's first word until a run is found or the map ends, for up to three zones,
// then marks the run, reading and writing back each of its words. The response
// register lets a new request start while the previous response stalls.
module frame_bitmap_allocator #(
   parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEFAULT,
   parameter int WORD_BITS = fba_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  fba_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output fba_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fba_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fba_pkg::ZONE_W-1:0]           csr_data
);
   import fba_pkg::*;

   localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW = $clog2(WORD_BITS);
   localparam int FW = ($clog2(NUM_FRAMES) + 2 > 14) ? $clog2(NUM_FRAMES) + 2 : 14;
   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
   localparam logic [FW-1:0] NUM_FRAMES_F = FW'(NUM_FRAMES);

   typedef enum logic [6:0] {
      ST_INIT = 7'b0000001,
      ST_IDLE = 7'b0000010,
      ST_ZONE = 7'b0000100,
      ST_SCAN = 7'b0001000,
      ST_WRD  = 7'b0010000,
      ST_WMOD = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      ZN_HIGH   = 2'b01,
      ZN_NORMAL = 2'b10,
      ZN_ALL    = 2'b11
   } zone_type;

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] map_q_ff;

   state_type state_ff, state_in;
   zone_type zone_ff, zone_in;
   req_type req_ff, req_in;
   logic [ZONE_W-1:0] high_ff, normal_ff;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic issue_done_ff, issue_done_in;
   logic pv_ff, pv_in;
   logic [AW-1:0] pw_ff, pw_in;
   logic [FW-1:0] run_ff, run_in;
   logic [AW-1:0] from_word_ff, from_word_in;
   logic [BW-1:0] from_bit_ff, from_bit_in;
   logic [FW-1:0] s_ff, s_in, e_ff, e_in;
   logic [AW-1:0] wr_w_ff, wr_w_in;
   logic set_ff, set_in;
   logic res_ok_ff, res_ok_in;
   logic [FRAME_W-1:0] res_frame_ff, res_frame_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [WORD_BITS-1:0] mem_wd;

   logic [WORD_BITS-1:0] busy, wmask;
   logic scan_hit;
   logic [BW-1:0] scan_bit;
   logic [FW-1:0] scan_run, need, start_ext, sum_ext, from_ext, hit_end;

   assign need = FW'(req_ff.frame_count);
   assign start_ext = FW'(req_data.start_frame);
   assign sum_ext = start_ext + FW'(req_data.frame_count);
   assign hit_end = (FW'(pw_ff) << BW) | FW'(scan_bit);

   always_comb begin
      unique case (zone_ff)
         ZN_HIGH:   from_ext = FW'(high_ff);
         ZN_NORMAL: from_ext = FW'(normal_ff);
         default:   from_ext = '0;
      endcase
   end

   // Frames past the map end and frames below the zone start count as busy.
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         logic [FW-1:0] fr;
         logic [FW-1:0] fw;
         fr = (FW'(pw_ff) << BW) | FW'(i);
         fw = (FW'(wr_w_ff) << BW) | FW'(i);
         busy[i] = map_q_ff[i] | (fr >= NUM_FRAMES_F) |
                   ((pw_ff == from_word_ff) && (BW'(i) < from_bit_ff));
         wmask[i] = (fw >= s_ff) && (fw <= e_ff);
      end
   end

   fba_word_scan #(
      .WORD_BITS(WORD_BITS),
      .FW(FW)
   ) u_scan (
      .busy(busy),
      .run_in(run_ff),
      .need(need),
      .hit(scan_hit),
      .hit_bit(scan_bit),
      .run_out(scan_run)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      zone_in = zone_ff;
      req_in = req_ff;
      scan_addr_in = scan_addr_ff;
      issue_done_in = issue_done_ff;
      pv_in = 1'b0;
      pw_in = scan_addr_ff;
      run_in = run_ff;
      from_word_in = from_word_ff;
      from_bit_in = from_bit_ff;
      s_in = s_ff;
      e_in = e_ff;
      wr_w_in = wr_w_ff;
      set_in = set_ff;
      res_ok_in = res_ok_ff;
      res_frame_in = res_frame_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_wa = wr_w_ff;
      mem_ra = wr_w_ff;
      mem_wd = '1;

      unique case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            if (wr_w_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               wr_w_in = wr_w_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_ok_in = 1'b0;
               res_frame_in = '0;
               state_in = ST_DONE;
               case (req_data.mode)
                  MODE_ALLOC: begin
                     if (req_data.frame_count != '0) begin
                        state_in = ST_ZONE;
                        if (req_data.want_high) begin
                           zone_in = ZN_HIGH;
                        end else if (req_data.want_normal) begin
                           zone_in = ZN_NORMAL;
                        end else begin
                           zone_in = ZN_ALL;
                        end
                     end
                  end
                  MODE_FREE, MODE_RESERVE: begin
                     if (start_ext < NUM_FRAMES_F) begin
                        res_ok_in = 1'b1;
                        if (req_data.frame_count != '0) begin
                           s_in = start_ext;
                           e_in = ((sum_ext > NUM_FRAMES_F) ? NUM_FRAMES_F : sum_ext) - 1'b1;
                           wr_w_in = start_ext[BW +: AW];
                           set_in = (req_data.mode == MODE_RESERVE);
                           state_in = ST_WRD;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ZONE: begin
            if (from_ext >= NUM_FRAMES_F) begin
               if (zone_ff == ZN_HIGH && req_ff.want_normal) begin
                  zone_in = ZN_NORMAL;
               end else if (zone_ff != ZN_ALL) begin
                  zone_in = ZN_ALL;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               scan_addr_in = from_ext[BW +: AW];
               from_word_in = from_ext[BW +: AW];
               from_bit_in = from_ext[BW-1:0];
               issue_done_in = 1'b0;
               run_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Reads stream one word per cycle; a hit or the last word stops
            // the stream so no stale word reaches the scanner afterward.
            if (!issue_done_ff && !(pv_ff && (scan_hit || pw_ff == LAST_WORD))) begin
               mem_re = 1'b1;
               mem_ra = scan_addr_ff;
               pv_in = 1'b1;
               if (scan_addr_ff == LAST_WORD) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end
            if (pv_ff) begin
               if (scan_hit) begin
                  s_in = hit_end + 1'b1 - need;
                  e_in = hit_end;
                  wr_w_in = s_in[BW +: AW];
                  set_in = 1'b1;
                  res_ok_in = 1'b1;
                  res_frame_in = s_in[FRAME_W-1:0];
                  state_in = ST_WRD;
               end else begin
                  run_in = scan_run;
                  if (pw_ff == LAST_WORD) begin
                     if (zone_ff == ZN_HIGH && req_ff.want_normal) begin
                        zone_in = ZN_NORMAL;
                        state_in = ST_ZONE;
                     end else if (zone_ff != ZN_ALL) begin
                        zone_in = ZN_ALL;
                        state_in = ST_ZONE;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               end
            end
         end
         ST_WRD: begin
            mem_re = 1'b1;
            state_in = ST_WMOD;
         end
         ST_WMOD: begin
            mem_we = 1'b1;
            mem_wd = set_ff ? (map_q_ff | wmask) : (map_q_ff & ~wmask);
            if (wr_w_ff == e_ff[BW +: AW]) begin
               state_in = ST_DONE;
            end else begin
               wr_w_in = wr_w_ff + 1'b1;
               state_in = ST_WRD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.success = res_ok_ff;
               rsp_data_in.result_frame = res_frame_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         map_q_ff <= map_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         wr_w_ff <= '0;
         pv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         high_ff <= HIGH_ZONE_RESET;
         normal_ff <= NORMAL_ZONE_RESET;
      end else begin
         state_ff <= state_in;
         wr_w_ff <= wr_w_in;
         pv_ff <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            if (csr_index == CSR_HIGH_ZONE) begin
               high_ff <= csr_data;
            end else if (csr_index == CSR_NORMAL_ZONE) begin
               normal_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      zone_ff <= zone_in;
      req_ff <= req_in;
      scan_addr_ff <= scan_addr_in;
      issue_done_ff <= issue_done_in;
      pw_ff <= pw_in;
      run_ff <= run_in;
      from_word_ff <= from_word_in;
      from_bit_ff <= from_bit_in;
      s_ff <= s_in;
      e_ff <= e_in;
      set_ff <= set_in;
      res_ok_ff <= res_ok_in;
      res_frame_ff <= res_frame_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
